[sv/fmavg_pkg.sv]
// shared constants and lane control type for the four-lane moving average
package fmavg_pkg;

	// field widths
	localparam int TICK_W     = 16;
	localparam int SAMPLE_W   = 16;
	localparam int IO_LANES   = 4;
	localparam int IN_DATA_W  = TICK_W + IO_LANES * SAMPLE_W;
	localparam int OUT_DATA_W = IO_LANES * SAMPLE_W;

	// parameter defaults
	localparam int WIN_LEN_DEF  = 10;
	localparam int LANE_CNT_DEF = 4;

	// per-cycle commands from the sequencer to every lane
	typedef struct packed {
		logic load;      // capture the lane sample of the accepted transfer
		logic wr;        // write the window store
		logic wr_zero;   // write zero instead of the sample (clearing pass)
		logic acc_clr;   // clear the accumulator
		logic acc_en;    // add the registered read data
		logic div_load;  // start the division from the accumulator
		logic div_step;  // one quotient bit
	} lane_ctrl_t;

endpackage

[sv/fmavg_ram.sv]
// generic single-write, single-read ram with registered read data
module fmavg_ram #(
	parameter int WIDTH = fmavg_pkg::SAMPLE_W,
	parameter int DEPTH = fmavg_pkg::WIN_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/fmavg_lane.sv]
// one averaging lane: window store, serial accumulator and bit-serial divider
module fmavg_lane #(
	parameter int WINDOW_LEN = fmavg_pkg::WIN_LEN_DEF
) (
	input  logic                              clk,
	input  fmavg_pkg::lane_ctrl_t             ctrl,
	input  logic [$clog2(WINDOW_LEN)-1:0]     waddr,
	input  logic [$clog2(WINDOW_LEN)-1:0]     raddr,
	input  logic [$clog2(WINDOW_LEN+1)-1:0]   divisor,
	input  logic [fmavg_pkg::SAMPLE_W-1:0]    sample,
	output logic [fmavg_pkg::SAMPLE_W-1:0]    result
);
	import fmavg_pkg::*;

	localparam int AW    = $clog2(WINDOW_LEN);
	localparam int NW    = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W = SAMPLE_W + AW;

	logic [SAMPLE_W-1:0] sample_q;
	logic [SAMPLE_W-1:0] wdata;
	logic [SAMPLE_W-1:0] rdata;
	logic [SUM_W-1:0]    acc_q;
	logic [SUM_W-1:0]    quo_q;
	logic [NW-1:0]       rem_q;
	logic                neg_q;
	logic [NW:0]         trial;
	logic                fits;
	logic [SUM_W-1:0]    signed_quo;

	// window store of this lane
	assign wdata = ctrl.wr_zero ? '0 : sample_q;

	fmavg_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_LEN)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.wr),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// sample capture and window sum
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sample_q <= sample;
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + {{AW{rdata[SAMPLE_W-1]}}, rdata};
		end
	end

	// restoring division of the magnitude, one quotient bit per cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			neg_q <= acc_q[SUM_W-1];
			quo_q <= acc_q[SUM_W-1] ? (SUM_W'(0) - acc_q) : acc_q;
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			rem_q <= fits ? NW'(trial - {1'b0, divisor}) : NW'(trial);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	// restore the sign, truncation toward zero
	assign signed_quo = neg_q ? (SUM_W'(0) - quo_q) : quo_q;
	assign result     = signed_quo[SAMPLE_W-1:0];

endmodule

[sv/fmavg_ctrl.sv]
// sequencer shared by all lanes: clearing pass, window addressing, sum and divide steps
module fmavg_ctrl #(
	parameter int WINDOW_LEN = fmavg_pkg::WIN_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fmavg_pkg::TICK_W-1:0]    tick,
	input  logic                            out_free,
	output logic                            res_valid,
	output fmavg_pkg::lane_ctrl_t           lane_ctrl,
	output logic [$clog2(WINDOW_LEN)-1:0]   waddr,
	output logic [$clog2(WINDOW_LEN)-1:0]   raddr,
	output logic [$clog2(WINDOW_LEN+1)-1:0] divisor
);
	import fmavg_pkg::*;

	localparam int AW    = $clog2(WINDOW_LEN);
	localparam int NW    = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W = SAMPLE_W + AW;
	localparam int CW    = $clog2(SUM_W);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_LEN - 1);
	localparam logic [CW-1:0] LAST_BIT  = CW'(SUM_W - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_SUM,
		ST_DRAIN,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] ptr_q;
	logic [NW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [CW-1:0] bit_q;
	logic          rvld_q;

	logic          warm;
	logic [AW:0]   wsum;
	logic [AW-1:0] warm_addr;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] ptr_inc;
	logic [NW-1:0] n_next;

	// slot mapping: logical slot j lives at (head + j) mod window length
	assign warm      = tick < TICK_W'(WINDOW_LEN);
	assign wsum      = {1'b0, head_q} + {1'b0, tick[AW-1:0]};
	assign warm_addr = (wsum >= (AW+1)'(WINDOW_LEN)) ? AW'(wsum - (AW+1)'(WINDOW_LEN))
	                                                 : wsum[AW-1:0];
	assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign ptr_inc   = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
	assign n_next    = warm ? (NW'(tick[AW-1:0]) + NW'(1)) : NW'(WINDOW_LEN);

	// state and registered control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			head_q  <= '0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			bit_q   <= '0;
			rvld_q  <= 1'b0;
		end else begin
			rvld_q <= (state_q == ST_SUM);
			unique case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_inc;
					if (ptr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						n_q     <= n_next;
						state_q <= ST_WRITE;
						if (warm) begin
							ptr_q <= warm_addr;
						end else begin
							// oldest entry is overwritten, window start moves up
							ptr_q  <= head_q;
							head_q <= head_inc;
						end
					end
				end
				ST_WRITE: begin
					ptr_q   <= head_q;
					cnt_q   <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					ptr_q <= ptr_inc;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == n_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					bit_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == LAST_BIT) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// lane commands
	assign in_ready           = (state_q == ST_IDLE);
	assign res_valid          = (state_q == ST_DONE);
	assign lane_ctrl.load     = (state_q == ST_IDLE) && in_valid;
	assign lane_ctrl.wr       = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign lane_ctrl.wr_zero  = (state_q == ST_CLEAR);
	assign lane_ctrl.acc_clr  = (state_q == ST_WRITE);
	assign lane_ctrl.acc_en   = rvld_q;
	assign lane_ctrl.div_load = (state_q == ST_LOAD);
	assign lane_ctrl.div_step = (state_q == ST_DIV);
	assign waddr              = ptr_q;
	assign raddr              = ptr_q;
	assign divisor            = n_q;

endmodule

[sv/four_lane_moving_average_core.sv]
// top level: sequencer, averaging lanes and the merging output register
//
// Moving average over four relative-velocity streams, one lane per stream.
// Input channel s_axis: a transfer carries a tick index and four Q8.8 samples.
// While the tick is below WINDOW_LEN the sample goes to slot tick and the lane
// gives the mean of slots 0..tick; from then on the window slides by one and
// the lane gives the window sum over WINDOW_LEN, truncated toward zero.
// Output channel m_axis: one transfer per input transfer, the four lane means.
// An input transfer takes the sequencer through the write, sum, drain, load,
// divide and done states; the sum reads n = min(tick + 1, WINDOW_LEN) window
// slots (one read of each lane's window ram per cycle) and the one-bit-per-cycle
// divider steps through the S = 16 + clog2(WINDOW_LEN) accumulator bits.
// A new item is taken only after the previous one has left the done state.
// After reset the window rams are swept to zero, one slot per cycle, over
// every slot; s_axis_tready stays low during the sweep.
// A finished result sits in the output register; the next item is accepted
// while it waits, and only a second result stalls until m_axis_tready is seen.
module four_lane_moving_average_core #(
	parameter int WINDOW_LEN = fmavg_pkg::WIN_LEN_DEF,
	parameter int LANE_COUNT = fmavg_pkg::LANE_CNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tick_index, lead_rel_vel, rear_rel_vel, preceding_rel_vel, following_rel_vel
	input  logic [fmavg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// lead_avg, rear_avg, preceding_avg, following_avg
	output logic [fmavg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import fmavg_pkg::*;

	localparam int AW = $clog2(WINDOW_LEN);
	localparam int NW = $clog2(WINDOW_LEN + 1);

	lane_ctrl_t          lane_ctrl;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	logic [NW-1:0]       divisor;
	logic                res_valid;
	logic                out_free;
	logic [SAMPLE_W-1:0] lane_sample [LANE_COUNT];
	logic [SAMPLE_W-1:0] lane_res    [LANE_COUNT];
	logic [OUT_DATA_W-1:0] merged;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// sequencer
	fmavg_ctrl #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.tick     (s_axis_tdata[TICK_W-1:0]),
		.out_free (out_free),
		.res_valid(res_valid),
		.lane_ctrl(lane_ctrl),
		.waddr    (waddr),
		.raddr    (raddr),
		.divisor  (divisor)
	);

	// lanes, extra lanes run on zero samples
	for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
		if (l < IO_LANES) begin : g_io
			assign lane_sample[l] = s_axis_tdata[TICK_W + l*SAMPLE_W +: SAMPLE_W];
		end else begin : g_zero
			assign lane_sample[l] = '0;
		end

		fmavg_lane #(
			.WINDOW_LEN(WINDOW_LEN)
		) u_lane (
			.clk    (clk),
			.ctrl   (lane_ctrl),
			.waddr  (waddr),
			.raddr  (raddr),
			.divisor(divisor),
			.sample (lane_sample[l]),
			.result (lane_res[l])
		);
	end

	// merge lane results into the output word, missing lanes read as zero
	for (genvar o = 0; o < IO_LANES; o++) begin : g_merge
		if (o < LANE_COUNT) begin : g_used
			assign merged[o*SAMPLE_W +: SAMPLE_W] = lane_res[o];
		end else begin : g_unused
			assign merged[o*SAMPLE_W +: SAMPLE_W] = '0;
		end
	end

	// output register
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_data_q <= merged;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

[sv/fmavg_checker.sv]
// port-level checks for the moving average core and their bind
module fmavg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [fmavg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// one item at a time: busy right after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	// a new result is loaded only from the finishing state, never while idle
	a_res_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared while idle");

	// clearing pass holds off input right after reset
	a_clear_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !s_axis_tready)
		else $error("input ready during clearing pass");

endmodule

bind four_lane_moving_average_core fmavg_checker u_fmavg_checker (.*);
